### rtl/core/rve_pkg.sv
package rve_pkg;

    localparam int MAX_DIM      = 4096;
    localparam int DIM_W        = 13;
    localparam int STRENGTH_W   = 16;
    localparam int COORD_W      = 12;
    localparam int CHAN_W       = 8;
    localparam int DELTA_W      = 14;
    localparam int SQ_W         = 28;
    localparam int RAD_IN_W     = 44;
    localparam int ROOT_W       = 22;
    localparam int SQRT_REM_W   = 25;
    localparam int NUM_W        = 38;
    localparam int DIVISOR_W    = 17;
    localparam int E16_W        = 20;
    localparam int Q30_W        = 31;
    localparam int FACTOR_W     = 17;

    localparam int SQRT_STEPS   = 22;
    localparam int DIV_STEPS    = 20;
    localparam int SERIES_TERMS = 16;
    localparam int SQUARINGS    = 4;

    // dx, q, root steps, product, overflow check, quotient steps
    localparam int RAD_LAT  = 2 + SQRT_STEPS + 2 + DIV_STEPS;
    // three stages a term, squarings, rounding
    localparam int EXP_LAT  = 3 * SERIES_TERMS + SQUARINGS + 1;
    localparam int PIPE_LAT = RAD_LAT + EXP_LAT + 1;

    localparam logic [E16_W-1:0] E16_LIMIT = 20'd786432;

    localparam logic [1:0] REG_FRAME_WIDTH      = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_FALLOFF_STRENGTH = 2'd2;

    localparam logic [DIM_W-1:0]      FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]      FRAME_HEIGHT_RST = 13'd480;
    localparam logic [STRENGTH_W-1:0] STRENGTH_RST     = 16'd205;

    typedef struct packed {
        logic             sat;
        logic [E16_W-1:0] e16;
    } expo_t;

endpackage

### rtl/core/rve_radius.sv
module rve_radius (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [rve_pkg::COORD_W-1:0]      pixel_column,
    input  logic [rve_pkg::COORD_W-1:0]      pixel_row,
    input  logic [rve_pkg::DIM_W-1:0]        frame_width,
    input  logic [rve_pkg::DIM_W-1:0]        frame_height,
    input  logic [rve_pkg::STRENGTH_W-1:0]   falloff_strength,
    output rve_pkg::expo_t                   expo
);

    logic signed [rve_pkg::DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [rve_pkg::SQ_W-1:0]    dx_sq, dy_sq;
    logic [rve_pkg::SQ_W-1:0]           q_reg;

    logic [rve_pkg::SQRT_REM_W-1:0] sq_rem_reg  [0:rve_pkg::SQRT_STEPS-1];
    logic [rve_pkg::ROOT_W-1:0]     sq_root_reg [0:rve_pkg::SQRT_STEPS-1];
    logic [rve_pkg::RAD_IN_W-1:0]   sq_v_reg    [0:rve_pkg::SQRT_STEPS-1];

    logic [rve_pkg::NUM_W-1:0]     num_reg;
    logic [rve_pkg::DIVISOR_W-1:0] divisor;
    logic                          sat_reg;
    logic [rve_pkg::DIVISOR_W:0]   rem0_reg;
    logic [rve_pkg::E16_W-1:0]     low0_reg;

    logic [rve_pkg::DIVISOR_W:0]   dv_rem_reg [0:rve_pkg::DIV_STEPS-1];
    logic [rve_pkg::E16_W-1:0]     dv_low_reg [0:rve_pkg::DIV_STEPS-1];
    logic [rve_pkg::E16_W-1:0]     dv_q_reg   [0:rve_pkg::DIV_STEPS-1];
    logic                          dv_sat_reg [0:rve_pkg::DIV_STEPS-1];

    assign divisor = {frame_height, 4'b0000};

    assign dx_sq = rve_pkg::SQ_W'(dx_reg) * rve_pkg::SQ_W'(dx_reg);
    assign dy_sq = rve_pkg::SQ_W'(dy_reg) * rve_pkg::SQ_W'(dy_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= $signed({1'b0, pixel_column, 1'b0}) - $signed({1'b0, frame_width});
            dy_reg <= $signed({1'b0, pixel_row, 1'b0}) - $signed({1'b0, frame_height});
            q_reg  <= $unsigned(dx_sq) + $unsigned(dy_sq);
        end
    end

    // one root bit a stage
    for (genvar i = 0; i < rve_pkg::SQRT_STEPS; i++) begin : g_sqrt
        logic [rve_pkg::SQRT_REM_W-1:0] rem_in;
        logic [rve_pkg::ROOT_W-1:0]     root_in;
        logic [rve_pkg::RAD_IN_W-1:0]   v_in;
        logic [rve_pkg::SQRT_REM_W-1:0] rem_sh;
        logic [rve_pkg::SQRT_REM_W-1:0] trial;
        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = {q_reg, 16'h0000};
        end else begin : g_next
            assign rem_in  = sq_rem_reg[i-1];
            assign root_in = sq_root_reg[i-1];
            assign v_in    = sq_v_reg[i-1];
        end
        assign rem_sh = {rem_in[rve_pkg::SQRT_REM_W-3:0],
                         v_in[rve_pkg::RAD_IN_W-1-2*i -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_v_reg[i] <= v_in;
                if (rem_sh >= trial) begin
                    sq_rem_reg[i]  <= rem_sh - trial;
                    sq_root_reg[i] <= {root_in[rve_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    sq_rem_reg[i]  <= rem_sh;
                    sq_root_reg[i] <= {root_in[rve_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= falloff_strength * sq_root_reg[rve_pkg::SQRT_STEPS-1];
            sat_reg  <= num_reg[rve_pkg::NUM_W-1:rve_pkg::E16_W] >= {1'b0, divisor};
            rem0_reg <= num_reg[rve_pkg::NUM_W-1:rve_pkg::E16_W];
            low0_reg <= num_reg[rve_pkg::E16_W-1:0];
        end
    end

    // one quotient bit a stage
    for (genvar i = 0; i < rve_pkg::DIV_STEPS; i++) begin : g_div
        logic [rve_pkg::DIVISOR_W:0] rem_in;
        logic [rve_pkg::E16_W-1:0]   low_in;
        logic [rve_pkg::E16_W-1:0]   q_in;
        logic                        sat_in;
        logic [rve_pkg::DIVISOR_W:0] rem_sh;
        logic                        ge;
        if (i == 0) begin : g_first
            assign rem_in = rem0_reg;
            assign low_in = low0_reg;
            assign q_in   = '0;
            assign sat_in = sat_reg;
        end else begin : g_next
            assign rem_in = dv_rem_reg[i-1];
            assign low_in = dv_low_reg[i-1];
            assign q_in   = dv_q_reg[i-1];
            assign sat_in = dv_sat_reg[i-1];
        end
        assign rem_sh = {rem_in[rve_pkg::DIVISOR_W-1:0], low_in[rve_pkg::E16_W-1-i]};
        assign ge     = rem_sh >= {1'b0, divisor};
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_low_reg[i] <= low_in;
                dv_sat_reg[i] <= sat_in;
                dv_q_reg[i]   <= {q_in[rve_pkg::E16_W-2:0], ge};
                dv_rem_reg[i] <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
            end
        end
    end

    assign expo.sat = dv_sat_reg[rve_pkg::DIV_STEPS-1];
    assign expo.e16 = dv_q_reg[rve_pkg::DIV_STEPS-1];

endmodule

### rtl/core/rve_exp.sv
module rve_exp (
    input  logic                           aclk,
    input  logic                           en,
    input  rve_pkg::expo_t                 expo,
    output logic [rve_pkg::FACTOR_W-1:0]   factor
);

    localparam int TN = rve_pkg::SERIES_TERMS;
    localparam int QW = rve_pkg::Q30_W;

    logic [QW-1:0]        a_m_reg   [1:TN];
    logic [QW-2:0]        a_x_reg   [1:TN];
    logic signed [31:0]   a_sum_reg [1:TN];
    logic                 a_z_reg   [1:TN];
    logic [QW-1:0]        b_q_reg   [1:TN];
    logic [QW-1:0]        b_m_reg   [1:TN];
    logic [QW-2:0]        b_x_reg   [1:TN];
    logic signed [31:0]   b_sum_reg [1:TN];
    logic                 b_z_reg   [1:TN];
    logic [QW-1:0]        c_t_reg   [1:TN];
    logic [QW-2:0]        c_x_reg   [1:TN];
    logic signed [31:0]   c_sum_reg [1:TN];
    logic                 c_z_reg   [1:TN];

    logic [QW-1:0] s_reg [1:rve_pkg::SQUARINGS];
    logic          z_reg [1:rve_pkg::SQUARINGS];
    logic [rve_pkg::FACTOR_W-1:0] factor_reg;

    for (genvar k = 1; k <= TN; k++) begin : g_term
        localparam logic [32:0] RECIP = 33'(64'd4294967296 / k);
        logic [QW-1:0]      t_in;
        logic [QW-2:0]      x_in;
        logic signed [31:0] sum_in;
        logic               z_in;
        logic [60:0]        prod;
        logic [63:0]        est;
        logic [QW-1:0]      rem;
        logic [QW-1:0]      t_new;
        if (k == 1) begin : g_first
            assign t_in   = 31'h4000_0000;
            assign x_in   = {expo.e16, 10'b0};
            assign sum_in = 32'sh4000_0000;
            assign z_in   = expo.sat || (expo.e16 >= rve_pkg::E16_LIMIT);
        end else begin : g_next
            assign t_in   = c_t_reg[k-1];
            assign x_in   = c_x_reg[k-1];
            assign sum_in = c_sum_reg[k-1];
            assign z_in   = c_z_reg[k-1];
        end
        assign prod  = t_in * x_in;
        assign est   = a_m_reg[k] * RECIP;
        assign rem   = b_m_reg[k] - QW'(b_q_reg[k] * 5'(k));
        assign t_new = (rem >= QW'(k)) ? b_q_reg[k] + 1'b1 : b_q_reg[k];
        always_ff @(posedge aclk) begin
            if (en) begin
                a_m_reg[k]   <= prod[60:30];
                a_x_reg[k]   <= x_in;
                a_sum_reg[k] <= sum_in;
                a_z_reg[k]   <= z_in;
                b_q_reg[k]   <= est[62:32];
                b_m_reg[k]   <= a_m_reg[k];
                b_x_reg[k]   <= a_x_reg[k];
                b_sum_reg[k] <= a_sum_reg[k];
                b_z_reg[k]   <= a_z_reg[k];
                c_t_reg[k]   <= t_new;
                c_x_reg[k]   <= b_x_reg[k];
                c_z_reg[k]   <= b_z_reg[k];
                if (k % 2 == 1) begin
                    c_sum_reg[k] <= b_sum_reg[k] - $signed({1'b0, t_new});
                end else begin
                    c_sum_reg[k] <= b_sum_reg[k] + $signed({1'b0, t_new});
                end
            end
        end
    end

    for (genvar i = 1; i <= rve_pkg::SQUARINGS; i++) begin : g_sq
        logic [QW-1:0] s_in;
        logic          z_in;
        logic [61:0]   sq;
        if (i == 1) begin : g_first
            assign s_in = c_sum_reg[TN][31] ? '0 : c_sum_reg[TN][QW-1:0];
            assign z_in = c_z_reg[TN];
        end else begin : g_next
            assign s_in = s_reg[i-1];
            assign z_in = z_reg[i-1];
        end
        assign sq = s_in * s_in;
        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[i] <= sq[60:30];
                z_reg[i] <= z_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            factor_reg <= z_reg[rve_pkg::SQUARINGS] ? '0
                        : rve_pkg::FACTOR_W'((s_reg[rve_pkg::SQUARINGS] + 31'd8192) >> 14);
        end
    end

    assign factor = factor_reg;

endmodule

### rtl/core/radial_exponential_vignette.sv
// Exponential radial vignette on a BGR pixel stream. Each beat carries one pixel
// with its column and row; the result beat carries the three channels scaled by
// exp(-strength * radius / height), the radius taken from the frame centre.
// One pixel a clock is accepted while the output is not stalled; the pipeline is
// built from the 22-stage square root, the 20-stage divider and the 16-term series
// of three stages each. The whole pipeline halts while a result waits on m_tready.
// Write the registers only while no beat is in flight. Sizes are taken from the
// low 13 bits of cfg_data; 0 there reads as 1, a value above 4096 reads as 4096.
module radial_exponential_vignette (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // pixel_column, pixel_row, blue_in, green_in, red_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // blue_out, green_out, red_out
);

    localparam int LAT = rve_pkg::PIPE_LAT;

    logic [rve_pkg::DIM_W-1:0]      frame_width_reg, frame_height_reg;
    logic [rve_pkg::STRENGTH_W-1:0] strength_reg;
    logic [rve_pkg::DIM_W-1:0]      dim_next;

    logic           en;
    logic [LAT-1:0] valid_reg;
    logic [23:0]    chan_reg [0:LAT-2];
    logic [23:0]    out_reg;

    rve_pkg::expo_t               expo;
    logic [rve_pkg::FACTOR_W-1:0] factor;
    logic [23:0]                  chan;

    always_comb begin
        dim_next = cfg_data[rve_pkg::DIM_W-1:0];
        if (dim_next == '0) begin
            dim_next = 13'd1;
        end else if (dim_next > 13'(rve_pkg::MAX_DIM)) begin
            dim_next = 13'(rve_pkg::MAX_DIM);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= rve_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= rve_pkg::FRAME_HEIGHT_RST;
            strength_reg     <= rve_pkg::STRENGTH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                rve_pkg::REG_FRAME_WIDTH:      frame_width_reg  <= dim_next;
                rve_pkg::REG_FRAME_HEIGHT:     frame_height_reg <= dim_next;
                rve_pkg::REG_FALLOFF_STRENGTH: strength_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !valid_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chan_reg[0] <= s_tdata[47:24];
            for (int i = 1; i < LAT - 1; i++) begin
                chan_reg[i] <= chan_reg[i-1];
            end
        end
    end

    rve_radius u_radius (
        .aclk             (aclk),
        .en               (en),
        .pixel_column     (s_tdata[11:0]),
        .pixel_row        (s_tdata[23:12]),
        .frame_width      (frame_width_reg),
        .frame_height     (frame_height_reg),
        .falloff_strength (strength_reg),
        .expo             (expo)
    );

    rve_exp u_exp (
        .aclk   (aclk),
        .en     (en),
        .expo   (expo),
        .factor (factor)
    );

    assign chan = chan_reg[LAT-2];

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg[7:0]   <= 8'((25'(chan[7:0])   * 25'(factor)) >> 16);
            out_reg[15:8]  <= 8'((25'(chan[15:8])  * 25'(factor)) >> 16);
            out_reg[23:16] <= 8'((25'(chan[23:16]) * 25'(factor)) >> 16);
        end
    end

    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_dims_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_width_reg != '0 && frame_height_reg != '0 &&
        frame_width_reg <= 13'(rve_pkg::MAX_DIM) &&
        frame_height_reg <= 13'(rve_pkg::MAX_DIM))
        else $error("frame size out of range");

    a_factor_max: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[LAT-2] |-> factor <= 17'd65536)
        else $error("factor above unity");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

### tb/sv/tb_radial_exponential_vignette.sv
module tb_radial_exponential_vignette;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE = 2'd3;

    class vignette_scoreboard;
        logic [63:0] width_q, height_q, strength_q;
        logic [23:0] pending_px[$];
        int          errors;

        function new();
            width_q    = 64'(rve_pkg::FRAME_WIDTH_RST);
            height_q   = 64'(rve_pkg::FRAME_HEIGHT_RST);
            strength_q = 64'(rve_pkg::STRENGTH_RST);
            errors     = 0;
        endfunction

        function logic [63:0] clamp_size(logic [63:0] v);
            logic [63:0] m;
            m = v & 64'h1FFF;
            if (m == 0) return 64'd1;
            if (m > 64'(rve_pkg::MAX_DIM)) return 64'(rve_pkg::MAX_DIM);
            return m;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                rve_pkg::REG_FRAME_WIDTH:      width_q = clamp_size(64'(val));
                rve_pkg::REG_FRAME_HEIGHT:     height_q = clamp_size(64'(val));
                rve_pkg::REG_FALLOFF_STRENGTH: strength_q = 64'(val);
                default: ;
            endcase
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] res, bit_q;
            res   = 0;
            bit_q = 64'd1 << 62;
            while (bit_q > v) bit_q = bit_q >> 2;
            while (bit_q != 0) begin
                if (v >= res + bit_q) begin
                    v   = v - (res + bit_q);
                    res = (res >> 1) + bit_q;
                end else begin
                    res = res >> 1;
                end
                bit_q = bit_q >> 2;
            end
            return res;
        endfunction

        function logic [63:0] gain_of(logic [63:0] e16);
            logic [63:0] x, term, s;
            longint      acc;
            if (e16 >= 64'(rve_pkg::E16_LIMIT)) return 64'd0;
            x    = e16 << 10;
            term = 64'd1 << 30;
            acc  = longint'(64'd1 << 30);
            for (int k = 1; k <= rve_pkg::SERIES_TERMS; k++) begin
                term = ((term * x) >> 30) / 64'(k);
                if (k % 2 == 1) acc = acc - longint'(term);
                else            acc = acc + longint'(term);
            end
            s = (acc > 0) ? 64'(acc) : 64'd0;
            for (int k = 0; k < rve_pkg::SQUARINGS; k++) s = (s * s) >> 30;
            return (s + (64'd1 << 13)) >> 14;
        endfunction

        // one accepted pixel beat -> one expected shaded pixel
        function void note_pixel(logic [47:0] d);
            longint      dx, dy;
            logic [63:0] q, r8, e16, g;
            logic [23:0] px;
            dx  = 2 * longint'(d[11:0]) - longint'(width_q);
            dy  = 2 * longint'(d[23:12]) - longint'(height_q);
            q   = 64'(dx * dx) + 64'(dy * dy);
            r8  = int_sqrt(q << 16);
            e16 = (strength_q * r8) / (64'd16 * height_q);
            g   = gain_of(e16);
            for (int j = 0; j < 3; j++) begin
                px[j*8 +: 8] = 8'((64'(d[24 + j*8 +: 8]) * g) >> 16);
            end
            pending_px.push_back(px);
        endfunction

        function void check_pixel(logic [23:0] got);
            logic [23:0] exp_px;
            bit          bad;
            if (pending_px.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", got);
                return;
            end
            exp_px = pending_px.pop_front();
            bad = 0;
            for (int j = 0; j < 3; j++) begin
                if (got[j*8 +: 8] !== exp_px[j*8 +: 8]) bad = 1;
            end
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch b/g/r: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             exp_px[7:0], exp_px[15:8], exp_px[23:16],
                             got[7:0], got[15:8], got[23:16]);
                end
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;

    vignette_scoreboard sb = new();
    bit  steady_flow = 0;
    int  hold_request = 0;

    radial_exponential_vignette u_dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata
    );

    always #5 aclk = ~aclk;

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_pixel(m_tdata);
            @(negedge aclk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_tready = 0;
                stall_left--;
            end else if (steady_flow || $urandom_range(0, 9) < 7) begin
                m_tready = 1;
            end else begin
                m_tready   = 0;
                stall_left = ($urandom_range(0, 19) == 0) ? int'($urandom_range(20, 60))
                                                          : int'($urandom_range(0, 2));
            end
        end
    end

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        @(negedge aclk);
        s_tvalid  = 0;
        cfg_we    = 1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 0;
    endtask

    task automatic send_pixel(logic [11:0] col, logic [11:0] row,
                              logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int gap;
        @(negedge aclk);
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? int'($urandom_range(10, 40))
                                               : int'($urandom_range(1, 3));
            s_tvalid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata  = {r, g, b, row, col};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(s_tdata);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        wait (sb.pending_px.size() == 0);
        repeat (rve_pkg::PIPE_LAT + 10) @(posedge aclk);
    endtask

    task automatic random_pixels(int n);
        logic [11:0] col, row;
        int          w, h;
        w = int'(sb.width_q);
        h = int'(sb.height_q);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                col = 12'($urandom);
                row = 12'($urandom);
            end else begin
                // near the centre, where the factor is not yet zero
                col = 12'((w / 2 + $urandom_range(0, 64) - 32) & 12'hFFF);
                row = 12'((h / 2 + $urandom_range(0, 64) - 32) & 12'hFFF);
            end
            send_pixel(col, row, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        logic [15:0] setting[6][3];
        setting = '{
            '{16'd1,    16'd1,    16'd0},
            '{16'd0,    16'd0,    16'd65535},
            '{16'd8191, 16'd5000, 16'd65535},
            '{16'd4096, 16'd4096, 16'd205},
            '{16'd640,  16'd480,  16'd4096},
            '{16'd100,  16'd37,   16'd32768}
        };
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // reset values
        send_pixel(12'd320, 12'd240, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd0,   12'd0,   8'd255, 8'd128, 8'd1);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd639, 12'd479, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd4095, 12'd0, 8'd200, 8'd100, 8'd50);
        send_pixel(12'd0, 12'd4095, 8'd255, 8'd0, 8'd255);
        drain();

        write_cfg(rve_pkg::REG_FALLOFF_STRENGTH, 16'd0);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd254, 8'd1);
        send_pixel(12'd0, 12'd0, 8'd127, 8'd128, 8'd255);
        drain();
        write_cfg(rve_pkg::REG_FALLOFF_STRENGTH, 16'd65535);
        send_pixel(12'd320, 12'd240, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd321, 12'd240, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
        drain();
        write_cfg(REG_SPARE, 16'hFFFF);
        send_pixel(12'd320, 12'd250, 8'd255, 8'd255, 8'd255);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_cfg(rve_pkg::REG_FRAME_WIDTH, setting[p][0]);
            write_cfg(rve_pkg::REG_FRAME_HEIGHT, setting[p][1]);
            write_cfg(rve_pkg::REG_FALLOFF_STRENGTH, setting[p][2]);
            if (p == 3) begin
                steady_flow  = 1;
                hold_request = 400;
                random_pixels(150);
                steady_flow = 0;
            end else begin
                random_pixels(60);
                steady_flow = 1;
                random_pixels(10);
                steady_flow = 0;
            end
            drain();
        end

        for (int p = 0; p < 2; p++) begin
            write_cfg(rve_pkg::REG_FRAME_WIDTH, 16'($urandom_range(1, 4096)));
            write_cfg(rve_pkg::REG_FRAME_HEIGHT, 16'($urandom_range(1, 4096)));
            write_cfg(rve_pkg::REG_FALLOFF_STRENGTH, 16'($urandom_range(0, 8192)));
            random_pixels(20);
            drain();
        end

        if (sb.errors == 0 && sb.pending_px.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
